FILE: sv/lpt_pkg.sv
package lpt_pkg;

   localparam int CMD_BITS = 2;
   localparam int STATUS_BITS = 3;
   localparam int SLOT_BITS = 6;
   localparam int COUNT_BITS = 7;
   localparam int EXPIRE_BITS = 16;
   localparam int KEY_BITS = 64;
   localparam int NOW_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CREATE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_EXPIRE = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_HIT = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_CREATED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_DONE = 3'd4;

   localparam logic [0:0] CSR_CAPACITY = 1'b0;
   localparam logic [0:0] CSR_EXPIRE = 1'b1;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic [KEY_BITS-1:0] address_high;
      logic [KEY_BITS-1:0] address_low;
      logic [NOW_BITS-1:0] now;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SLOT_BITS-1:0] slot;
      logic [COUNT_BITS-1:0] removed_count;
   } rsp_type;

endpackage

FILE: sv/lpt_ram.sv
module lpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: sv/lpt_queue.sv
// Two-entry queue between the front end and the table engine.
module lpt_queue import lpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    deq_valid,
   input  logic    deq_ready,
   output req_type deq_data
);
   req_type     entry_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic        push, pop;

   assign req_stall = count_ff == 2'd2;
   assign push = req_valid && !req_stall;
   assign deq_valid = count_ff != 2'd0;
   assign pop = deq_valid && deq_ready;
   assign deq_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end
endmodule

FILE: sv/lpt_engine.sv
module lpt_engine import lpt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  req_type                cmd_data,
   input  logic [COUNT_BITS-1:0]  capacity,
   input  logic [EXPIRE_BITS-1:0] expire_seconds,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_SCAN    = 10'b0000000010,
      S_FREE    = 10'b0000000100,
      S_UNLINK  = 10'b0000001000,
      S_LINK    = 10'b0000010000,
      S_APPEND  = 10'b0000100000,
      S_EXP_RD  = 10'b0001000000,
      S_EXP_CHK = 10'b0010000000,
      S_CLEAR   = 10'b0100000000,
      S_OUT     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   req_type cmd_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [DEPTH-1:0] valid_ff;
   logic [AW-1:0] newest_ff, oldest_ff, slot_ff;
   logic [COUNT_BITS-1:0] free_ff, count_ff;
   rsp_type res_ff;
   rsp_type out_ff;
   logic out_valid_ff;

   // memories
   logic [AW-1:0] key_rd_addr;
   logic [KEY_BITS-1:0] khi_rd, klo_rd;
   logic [TIME_BITS-1:0] stamp_rd;
   logic [AW-1:0] newer_rd, older_rd;
   logic key_we, stamp_we;
   logic [AW-1:0] key_wa, stamp_wa;
   logic nw_we, ol_we;
   logic [AW-1:0] nw_wa, ol_wa, nw_wd, ol_wd, nw_ra, ol_ra;
   logic [TIME_BITS-1:0] now_t;
   logic rd_ok_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [TIME_BITS:0] limit;

   assign now_t = TIME_BITS'(cmd_ff.now);

   lpt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_khi (
      .clock, .wr_en(key_we), .wr_addr(key_wa), .wr_data(cmd_ff.address_high),
      .rd_addr(key_rd_addr), .rd_data(khi_rd));
   lpt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_klo (
      .clock, .wr_en(key_we), .wr_addr(key_wa), .wr_data(cmd_ff.address_low),
      .rd_addr(key_rd_addr), .rd_data(klo_rd));
   lpt_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_stamp (
      .clock, .wr_en(stamp_we), .wr_addr(stamp_wa), .wr_data(now_t),
      .rd_addr(key_rd_addr), .rd_data(stamp_rd));
   lpt_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_newer (
      .clock, .wr_en(nw_we), .wr_addr(nw_wa), .wr_data(nw_wd),
      .rd_addr(nw_ra), .rd_data(newer_rd));
   lpt_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_older (
      .clock, .wr_en(ol_we), .wr_addr(ol_wa), .wr_data(ol_wd),
      .rd_addr(ol_ra), .rd_data(older_rd));

   // Scan reads one entry per cycle; its data is compared in the following cycle.
   logic hit_now, free_now;
   assign hit_now = rd_ok_ff && valid_ff[rd_idx_ff] &&
                    khi_rd == cmd_ff.address_high && klo_rd == cmd_ff.address_low;
   assign free_now = !valid_ff[idx_ff[AW-1:0]];
   assign limit = {1'b0, stamp_rd} + (TIME_BITS+1)'(expire_seconds);

   logic chain_empty;
   assign chain_empty = !valid_ff[oldest_ff];

   assign cmd_ready = state_ff == S_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   logic [DEPTH-1:0] valid_in;
   logic [AW-1:0] newest_in, oldest_in, slot_in;
   logic [COUNT_BITS-1:0] free_in, count_in;
   logic out_valid_in, rd_ok_in;
   rsp_type res_in, out_in;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      slot_in = slot_ff;
      free_in = free_ff;
      count_in = count_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      rd_ok_in = 1'b0;
      key_rd_addr = idx_ff[AW-1:0];
      key_we = 1'b0;
      key_wa = slot_ff;
      stamp_we = 1'b0;
      stamp_wa = slot_ff;
      nw_we = 1'b0;
      ol_we = 1'b0;
      nw_wa = slot_ff;
      ol_wa = slot_ff;
      nw_wd = slot_ff;
      ol_wd = slot_ff;
      nw_ra = slot_ff;
      ol_ra = slot_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               idx_in = '0;
               count_in = '0;
               res_in = '0;
               case (cmd_data.command)
                  CMD_LOOKUP, CMD_CREATE: state_in = S_SCAN;
                  CMD_EXPIRE: state_in = S_EXP_RD;
                  default: state_in = S_CLEAR;
               endcase
            end
         end
         S_SCAN: begin
            if (hit_now) begin
               slot_in = rd_idx_ff;
               state_in = S_UNLINK;
            end else if (idx_ff == CW'(DEPTH)) begin
               if (cmd_ff.command == CMD_LOOKUP) begin
                  res_in.status = ST_NOT_FOUND;
                  state_in = S_OUT;
               end else if (free_ff == '0) begin
                  res_in.status = ST_FULL;
                  state_in = S_OUT;
               end else begin
                  idx_in = '0;
                  state_in = S_FREE;
               end
            end else begin
               rd_ok_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FREE: begin
            if (free_now) begin
               slot_in = idx_ff[AW-1:0];
               key_we = 1'b1;
               key_wa = idx_ff[AW-1:0];
               stamp_we = 1'b1;
               stamp_wa = idx_ff[AW-1:0];
               if (chain_empty) begin
                  oldest_in = idx_ff[AW-1:0];
               end else begin
                  ol_we = 1'b1;
                  ol_wa = idx_ff[AW-1:0];
                  ol_wd = newest_ff;
                  nw_we = 1'b1;
                  nw_wa = newest_ff;
                  nw_wd = idx_ff[AW-1:0];
               end
               newest_in = idx_ff[AW-1:0];
               valid_in[idx_ff[AW-1:0]] = 1'b1;
               free_in = free_ff - 1'b1;
               res_in.status = ST_CREATED;
               res_in.slot = SLOT_BITS'(idx_ff[AW-1:0]);
               state_in = S_OUT;
            end else if (idx_ff == LAST) begin
               res_in.status = ST_FULL;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_UNLINK: begin
            // link memories read at slot in this cycle
            stamp_we = 1'b1;
            res_in.status = ST_HIT;
            res_in.slot = SLOT_BITS'(slot_ff);
            if (slot_ff == newest_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            // slot is not newest, so its newer neighbor is valid
            ol_we = 1'b1;
            ol_wa = newer_rd;
            ol_wd = older_rd;
            if (slot_ff == oldest_ff) begin
               oldest_in = newer_rd;
            end else begin
               nw_we = 1'b1;
               nw_wa = older_rd;
               nw_wd = newer_rd;
            end
            state_in = S_APPEND;
         end
         S_APPEND: begin
            ol_we = 1'b1;
            ol_wa = slot_ff;
            ol_wd = newest_ff;
            nw_we = 1'b1;
            nw_wa = newest_ff;
            nw_wd = slot_ff;
            newest_in = slot_ff;
            state_in = S_OUT;
         end
         S_EXP_RD: begin
            key_rd_addr = oldest_ff;
            nw_ra = oldest_ff;
            if (chain_empty || idx_ff == CW'(DEPTH)) begin
               res_in.status = ST_DONE;
               res_in.removed_count = count_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (limit > {1'b0, now_t}) begin
               res_in.status = ST_DONE;
               res_in.removed_count = count_ff;
               state_in = S_OUT;
            end else begin
               valid_in[oldest_ff] = 1'b0;
               if (oldest_ff != newest_ff) begin
                  oldest_in = newer_rd;
               end
               if (free_ff != COUNT_MAX) free_in = free_ff + 1'b1;
               if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               state_in = S_EXP_RD;
            end
         end
         S_CLEAR: begin
            if (valid_ff[idx_ff[AW-1:0]] && count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (idx_ff == LAST) begin
               valid_in = '0;
               newest_in = '0;
               oldest_in = '0;
               free_in = capacity;
               res_in.status = ST_DONE;
               res_in.removed_count = count_in;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_OUT: begin
            // result register is loaded only once the previous transfer is gone
            if (!out_valid_ff || !rsp_stall) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         free_ff <= 7'd64;
         out_valid_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         free_ff <= free_in;
         out_valid_ff <= out_valid_in;
         rd_ok_ff <= rd_ok_in;
      end
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      count_ff <= count_in;
      res_ff <= res_in;
      out_ff <= out_in;
      rd_idx_ff <= idx_ff[AW-1:0];
      if (state_ff == S_IDLE && cmd_valid) begin
         cmd_ff <= cmd_data;
      end
   end
endmodule

FILE: sv/lru_peer_table_with_expiry.sv
// The engine handles one item at a time; the next is accepted once the result
// is registered and the engine is back in idle, so lookup and create throughput
// is set by the key scan, which reads one entry per cycle, and by output stalls.
// Synchronous active-high reset empties the table, sets capacity 64, expiry 30.
module lru_peer_table_with_expiry import lpt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [EXPIRE_BITS-1:0]  csr_data
);
   logic [COUNT_BITS-1:0] capacity_ff;
   logic [EXPIRE_BITS-1:0] expire_ff;
   logic q_valid, q_ready;
   req_type q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 7'd64;
         expire_ff <= 16'd30;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY: capacity_ff <= csr_data[COUNT_BITS-1:0];
            CSR_EXPIRE: expire_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lpt_queue u_queue (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .deq_valid(q_valid), .deq_ready(q_ready), .deq_data(q_data));

   lpt_engine #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .capacity(capacity_ff), .expire_seconds(expire_ff),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

FILE: bench/lru_peer_table_with_expiry_tb.sv
`timescale 1ns / 100ps

module lru_peer_table_with_expiry_tb;
   import lpt_pkg::*;

   localparam int SLOTS = 64;
   localparam int STALL_LIMIT = 5000;
   localparam int POOL = 24;

   // Tracks the peer table contents and recency chain; holds the results due.
   class peer_table_tracker;
      bit [KEY_BITS-1:0] key_hi[SLOTS];
      bit [KEY_BITS-1:0] key_lo[SLOTS];
      bit [NOW_BITS-1:0] stamp[SLOTS];
      bit used[SLOTS];
      bit [SLOT_BITS-1:0] newer[SLOTS];
      bit [SLOT_BITS-1:0] older[SLOTS];
      bit [SLOT_BITS-1:0] newest;
      bit [SLOT_BITS-1:0] oldest;
      int unsigned free_slots;
      bit [COUNT_BITS-1:0] capacity;
      bit [EXPIRE_BITS-1:0] expire_secs;
      rsp_type pending_rsps[$];
      int errors;
      int tally[5];

      function new();
         capacity = 7'd64;
         expire_secs = 16'd30;
         free_slots = 64;
         newest = 0;
         oldest = 0;
         errors = 0;
         foreach (used[i]) used[i] = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void set_reg(logic idx, bit [EXPIRE_BITS-1:0] v);
         if (idx == CSR_CAPACITY) capacity = v[COUNT_BITS-1:0];
         else expire_secs = v;
      endfunction

      function void append_newest(int s);
         if (!used[oldest]) begin
            oldest = SLOT_BITS'(s);
         end else begin
            older[s] = newest;
            newer[newest] = SLOT_BITS'(s);
         end
         newest = SLOT_BITS'(s);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int s;
         bit found;
         int n;
         bit [NOW_BITS:0] lim;
         e = '0;
         s = 0;
         found = 0;
         n = 0;
         case (r.command)
            CMD_LOOKUP, CMD_CREATE: begin
               for (int i = 0; i < SLOTS; i++)
                  if (used[i] && key_hi[i] == r.address_high && key_lo[i] == r.address_low) begin
                     found = 1;
                     s = i;
                     break;
                  end
               if (found) begin
                  stamp[s] = r.now;
                  if (s != newest) begin
                     older[newer[s]] = older[s];
                     if (s == oldest) oldest = newer[s];
                     else newer[older[s]] = newer[s];
                     append_newest(s);
                  end
                  e.status = ST_HIT;
                  e.slot = SLOT_BITS'(s);
               end else if (r.command == CMD_LOOKUP) begin
                  e.status = ST_NOT_FOUND;
               end else begin
                  if (free_slots != 0)
                     for (int i = 0; i < SLOTS; i++)
                        if (!used[i]) begin
                           found = 1;
                           s = i;
                           break;
                        end
                  if (found) begin
                     key_hi[s] = r.address_high;
                     key_lo[s] = r.address_low;
                     stamp[s] = r.now;
                     append_newest(s);
                     used[s] = 1;
                     free_slots--;
                     e.status = ST_CREATED;
                     e.slot = SLOT_BITS'(s);
                  end else begin
                     e.status = ST_FULL;
                  end
               end
            end
            CMD_EXPIRE: begin
               while (n < SLOTS && used[oldest]) begin
                  lim = {1'b0, stamp[oldest]} + (NOW_BITS+1)'(expire_secs);
                  if (lim > {1'b0, r.now}) break;
                  used[oldest] = 0;
                  if (oldest != newest) oldest = newer[oldest];
                  if (free_slots < 127) free_slots++;
                  n++;
               end
               e.status = ST_DONE;
               e.removed_count = COUNT_BITS'(n);
            end
            default: begin
               foreach (used[i]) if (used[i]) n++;
               foreach (used[i]) used[i] = 0;
               newest = 0;
               oldest = 0;
               free_slots = 32'(capacity);
               e.status = ST_DONE;
               e.removed_count = COUNT_BITS'(n);
            end
         endcase
         pending_rsps.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         e = pending_rsps.pop_front();
         if (got.status != e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.slot != e.slot) begin
            $display("%0t: slot expected %0d got %0d", $time, e.slot, got.slot);
            errors++;
         end
         if (got.removed_count != e.removed_count) begin
            $display("%0t: removed_count expected %0d got %0d", $time, e.removed_count,
                     got.removed_count);
            errors++;
         end
         if (got.status < 5) tally[got.status]++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [EXPIRE_BITS-1:0] csr_data;

   peer_table_tracker table_model;
   bit quiet;
   int hold_left;
   int idle_count;
   int sent;
   bit [NOW_BITS-1:0] tnow;
   bit [KEY_BITS-1:0] pool_hi[POOL];
   bit [KEY_BITS-1:0] pool_lo[POOL];

   lru_peer_table_with_expiry dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) table_model.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("lru_peer_table_with_expiry_tb: done, errors");
         $finish;
      end
   end

   task automatic send_item(req_type r);
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      table_model.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, bit [EXPIRE_BITS-1:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      table_model.set_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (table_model.pending_rsps.size() != 0);
      repeat (2 * SLOTS + 10) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type make_item(logic [CMD_BITS-1:0] c, bit [KEY_BITS-1:0] hi,
                                         bit [KEY_BITS-1:0] lo, bit [NOW_BITS-1:0] t);
      req_type r;
      r.command = c;
      r.address_high = hi;
      r.address_low = lo;
      r.now = t;
      return r;
   endfunction

   function automatic req_type random_item(int fresh_pct);
      int k;
      int pick;
      logic [CMD_BITS-1:0] c;
      pick = $urandom_range(99);
      if (pick < 40) c = CMD_CREATE;
      else if (pick < 75) c = CMD_LOOKUP;
      else if (pick < 96) c = CMD_EXPIRE;
      else c = CMD_CLEAR;
      tnow += $urandom_range(0, 6);
      k = $urandom_range(POOL - 1);
      if (c == CMD_EXPIRE)
         return make_item(c, {$urandom, $urandom}, {$urandom, $urandom},
                          tnow + $urandom_range(0, 40));
      if ($urandom_range(99) < fresh_pct)
         return make_item(c, {$urandom, $urandom}, {$urandom, $urandom}, tnow);
      return make_item(c, pool_hi[k], pool_lo[k], tnow);
   endfunction

   task automatic run_phase(bit [6:0] cap, bit [15:0] secs, int count, int fresh_pct);
      write_reg(CSR_CAPACITY, EXPIRE_BITS'(cap));
      write_reg(CSR_EXPIRE, secs);
      tnow = $urandom;
      send_item(make_item(CMD_CLEAR, '0, '0, tnow));
      repeat (count) send_item(random_item(fresh_pct));
      drain();
   endtask

   localparam bit [KEY_BITS-1:0] ONES = '1;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CAPACITY;
      csr_data = '0;
      quiet = 1'b0;
      hold_left = 0;
      idle_count = 0;
      sent = 0;
      table_model = new();
      foreach (pool_hi[i]) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: defaults, key extremes, recency moves, non-wrapping expiry sum
      send_item(make_item(CMD_LOOKUP, '0, '0, 0));
      send_item(make_item(CMD_CREATE, '0, '0, 0));
      send_item(make_item(CMD_CREATE, ONES, ONES, 32'hFFFF_FFFF));
      send_item(make_item(CMD_CREATE, ONES, '0, 5));
      send_item(make_item(CMD_LOOKUP, ONES, '0, 6));
      send_item(make_item(CMD_LOOKUP, '0, ONES, 6));
      send_item(make_item(CMD_LOOKUP, '0, '0, 7));
      send_item(make_item(CMD_CREATE, ONES, ONES, 32'hFFFF_FFFF));
      send_item(make_item(CMD_EXPIRE, '0, '0, 36));
      send_item(make_item(CMD_EXPIRE, '0, '0, 32'hFFFF_FFFF));
      send_item(make_item(CMD_CREATE, ONES, ONES, 32'hFFFF_FFF0));
      send_item(make_item(CMD_EXPIRE, '0, '0, 0));
      send_item(make_item(CMD_CLEAR, ONES, ONES, 0));
      send_item(make_item(CMD_CLEAR, '0, '0, 0));
      drain();
      write_reg(CSR_EXPIRE, 16'hFFFF);
      write_reg(CSR_CAPACITY, 16'd1);
      send_item(make_item(CMD_CLEAR, '0, '0, 0));
      send_item(make_item(CMD_CREATE, ONES, ONES, 32'hFFFF_0000));
      send_item(make_item(CMD_CREATE, '0, '0, 1));
      send_item(make_item(CMD_EXPIRE, '0, '0, 32'hFFFF_FFFF));
      send_item(make_item(CMD_LOOKUP, ONES, ONES, 2));
      drain();

      // receiver holds off at the start so the single-item engine backs up
      hold_left = 300;
      run_phase(7'd64, 16'd30, 120, 10);
      run_phase(7'd3, 16'd0, 70, 10);
      run_phase(7'd100, 16'd65535, 100, 80);
      quiet = 1'b1;
      run_phase(7'd0, 16'd5, 25, 10);
      run_phase(7'd64, 16'd12, 70, 20);
      quiet = 1'b0;

      $display("sent %0d requests: %0d hits, %0d created, %0d misses, %0d full, %0d expire/clear",
               sent, table_model.tally[0], table_model.tally[1], table_model.tally[2],
               table_model.tally[3], table_model.tally[4]);
      $display("capacities 0..100 and expiry 0..65535 exercised, with a long response hold");
      if (table_model.errors == 0 && table_model.pending_rsps.size() == 0) begin
         $display("lru_peer_table_with_expiry_tb: done, clean");
      end else begin
         $display("lru_peer_table_with_expiry_tb: done, errors");
      end
      $finish;
   end

endmodule
